FILE: rtl/fddp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and literal-matching helpers for the
// form-data disposition parser. No dependencies.
package fddp_pkg;

   localparam int MAX_LEN_DEFAULT = 4096;
   localparam int OFFSET_W        = 12;
   localparam int RSP_DATA_W      = 56;

   localparam logic [OFFSET_W-1:0] LEN_SAT = {OFFSET_W{1'b1}};

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   localparam logic [3:0] FORM_LEN = 4'd9;
   localparam logic [3:0] NAME_LEN = 4'd4;
   localparam logic [3:0] FILE_LEN = 4'd8;
   localparam logic [3:0] IDX_SAT  = 4'd15;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECT   = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] start;
      logic [OFFSET_W-1:0] len;
   } span_type;

   typedef struct packed {
      status_type status;
      span_type   name;
      span_type   file;
   } result_type;

   // One byte handed from the input register to the parser.
   typedef struct packed {
      logic       fire;
      logic [7:0] data;
      logic       last;
   } step_type;

   // Match a byte against "form-data" at a given index.
   function automatic logic form_char_ok(input logic [3:0] idx, input logic [7:0] c);
      logic [7:0] exp;
      logic       hit;
      hit = 1'b1;
      case (idx)
         4'd0:    exp = "f";
         4'd1:    exp = "o";
         4'd2:    exp = "r";
         4'd3:    exp = "m";
         4'd4:    exp = "-";
         4'd5:    exp = "d";
         4'd6:    exp = "a";
         4'd7:    exp = "t";
         4'd8:    exp = "a";
         default: begin
            exp = 8'h00;
            hit = 1'b0;
         end
      endcase
      return hit && (exp == c);
   endfunction

   // Match a byte against "name".
   function automatic logic name_char_ok(input logic [3:0] idx, input logic [7:0] c);
      logic [7:0] exp;
      logic       hit;
      hit = 1'b1;
      case (idx)
         4'd0:    exp = "n";
         4'd1:    exp = "a";
         4'd2:    exp = "m";
         4'd3:    exp = "e";
         default: begin
            exp = 8'h00;
            hit = 1'b0;
         end
      endcase
      return hit && (exp == c);
   endfunction

   // Match a byte against "filename".
   function automatic logic file_char_ok(input logic [3:0] idx, input logic [7:0] c);
      logic [7:0] exp;
      logic       hit;
      hit = 1'b1;
      case (idx)
         4'd0:    exp = "f";
         4'd1:    exp = "i";
         4'd2:    exp = "l";
         4'd3:    exp = "e";
         4'd4:    exp = "n";
         4'd5:    exp = "a";
         4'd6:    exp = "m";
         4'd7:    exp = "e";
         default: begin
            exp = 8'h00;
            hit = 1'b0;
         end
      endcase
      return hit && (exp == c);
   endfunction

endpackage

FILE: rtl/fddp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the parser: holds one request beat until the parser takes it.
// Depends on fddp_pkg.
module fddp_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              out_free,
   output fddp_pkg::step_type step
);
   import fddp_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       fire;

   // A final byte needs a free result slot; other bytes always go.
   assign fire       = valid_ff && (!last_ff || out_free);
   assign req_tready = !valid_ff || fire;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign step.fire = fire;
   assign step.data = data_ff;
   assign step.last = last_ff;

endmodule

FILE: rtl/fddp_parse_core.sv
`timescale 1ns / 1ps
// Parser state and next-state logic: segment phases, literal matching,
// span capture and the result of a final byte. Depends on fddp_pkg.
module fddp_parse_core #(
   parameter int MAX_LEN = fddp_pkg::MAX_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fddp_pkg::step_type   step,
   output logic                 emit,
   output fddp_pkg::result_type result
);
   import fddp_pkg::*;

   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_LEN);

   typedef enum logic [6:0] {
      PH_LEAD        = 7'b0000001,
      PH_TOKEN       = 7'b0000010,
      PH_TOKEN_SPACE = 7'b0000100,
      PH_PRE_VAL     = 7'b0001000,
      PH_VALUE       = 7'b0010000,
      PH_POST        = 7'b0100000,
      PH_BAD         = 7'b1000000
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                first_ff, first_in;
   logic [3:0]          idx_ff, idx_in;
   logic                bad_ff, bad_in;
   logic                kname_ff, kname_in;
   logic                kfile_ff, kfile_in;
   logic [OFFSET_W-1:0] vstart_ff, vstart_in;
   logic [OFFSET_W-1:0] vlen_ff, vlen_in;
   span_type            hname_ff, hname_in;
   span_type            hfile_ff, hfile_in;
   logic                long_ff, long_in;

   logic [7:0]          c;
   logic                parse_en;
   logic                feed_on;
   logic                do_end;
   logic                seg_ok;
   logic [POS_W-1:0]    pos_next;
   logic [POS_W+OFFSET_W-1:0] pos_wide;
   span_type            cur_span;

   assign c        = step.data;
   assign pos_next = pos_ff + 1'b1;
   assign pos_wide = {{OFFSET_W{1'b0}}, pos_next};
   assign emit     = step.fire && step.last;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      first_in  = first_ff;
      idx_in    = idx_ff;
      bad_in    = bad_ff;
      kname_in  = kname_ff;
      kfile_in  = kfile_ff;
      vstart_in = vstart_ff;
      vlen_in   = vlen_ff;
      hname_in  = hname_ff;
      hfile_in  = hfile_ff;
      long_in   = long_ff;
      seg_ok    = 1'b0;
      cur_span  = '{found: 1'b1, start: vstart_ff, len: vlen_ff};

      // Bytes past the length limit are counted as overflow, not parsed.
      parse_en = step.fire && (pos_ff < MaxPos) && !long_ff;
      feed_on  = !(bad_ff && !first_ff);
      if (step.fire) begin
         if (pos_ff >= MaxPos) begin
            long_in = 1'b1;
         end else begin
            pos_in = pos_next;
         end
      end

      if (parse_en && feed_on && (c != CH_SEMI)) begin
         if ((phase_in == PH_LEAD) && (c != CH_SPACE)) begin
            phase_in = PH_TOKEN;
         end
         case (phase_in)
            PH_TOKEN: begin
               if (c == CH_SPACE) begin
                  phase_in = PH_TOKEN_SPACE;
               end else if (!first_ff && (c == CH_EQ)) begin
                  phase_in = PH_PRE_VAL;
               end else begin
                  if (first_ff) begin
                     if (!form_char_ok(idx_ff, c)) bad_in = 1'b1;
                  end else begin
                     if (!name_char_ok(idx_ff, c)) kname_in = 1'b0;
                     if (!file_char_ok(idx_ff, c)) kfile_in = 1'b0;
                  end
                  idx_in = (idx_ff < IDX_SAT) ? idx_ff + 4'd1 : IDX_SAT;
               end
            end
            PH_TOKEN_SPACE: begin
               if (c != CH_SPACE) begin
                  if (first_ff) begin
                     bad_in = 1'b1;
                  end else if (c == CH_EQ) begin
                     phase_in = PH_PRE_VAL;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
            end
            PH_PRE_VAL: begin
               if (c == CH_QUOTE) begin
                  phase_in  = PH_VALUE;
                  vstart_in = pos_wide[OFFSET_W-1:0];
                  vlen_in   = '0;
               end else if (c != CH_SPACE) begin
                  phase_in = PH_BAD;
               end
            end
            PH_VALUE: begin
               if (c == CH_QUOTE) begin
                  phase_in = PH_POST;
               end else if (vlen_ff < LEN_SAT) begin
                  vlen_in = vlen_ff + 1'b1;
               end
            end
            PH_POST: begin
               if (c != CH_SPACE) phase_in = PH_BAD;
            end
            default: begin
            end
         endcase
      end

      // Close the segment on ';' or at the final byte of the value.
      do_end = parse_en && (((c == CH_SEMI) && feed_on) || (step.last && (c != CH_SEMI)));
      if (do_end) begin
         if (first_in) begin
            seg_ok = ((phase_in == PH_TOKEN) || (phase_in == PH_TOKEN_SPACE)) &&
                     !bad_in && (idx_in == FORM_LEN);
            if (!seg_ok) bad_in = 1'b1;
            first_in = 1'b0;
         end else if (phase_in == PH_POST) begin
            if (kname_in && (idx_in == NAME_LEN)) begin
               hname_in = cur_span;
            end else if (kfile_in && (idx_in == FILE_LEN)) begin
               hfile_in = cur_span;
            end
         end
         phase_in = PH_LEAD;
         idx_in   = '0;
         kname_in = 1'b1;
         kfile_in = 1'b1;
      end

      // Result of the final byte, from the state after this byte.
      if (long_in) begin
         result = '{status: STATUS_OVERFLOW, name: '0, file: '0};
      end else if (bad_in) begin
         result = '{status: STATUS_REJECT, name: '0, file: '0};
      end else begin
         result = '{status: STATUS_OK, name: hname_in, file: hfile_in};
      end

      // Drop all state once the value ends.
      if (emit) begin
         phase_in  = PH_LEAD;
         pos_in    = '0;
         first_in  = 1'b1;
         idx_in    = '0;
         bad_in    = 1'b0;
         kname_in  = 1'b1;
         kfile_in  = 1'b1;
         vstart_in = '0;
         vlen_in   = '0;
         hname_in  = '0;
         hfile_in  = '0;
         long_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         pos_ff    <= '0;
         first_ff  <= 1'b1;
         idx_ff    <= '0;
         bad_ff    <= 1'b0;
         kname_ff  <= 1'b1;
         kfile_ff  <= 1'b1;
         vstart_ff <= '0;
         vlen_ff   <= '0;
         hname_ff  <= '0;
         hfile_ff  <= '0;
         long_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         idx_ff    <= idx_in;
         bad_ff    <= bad_in;
         kname_ff  <= kname_in;
         kfile_ff  <= kfile_in;
         vstart_ff <= vstart_in;
         vlen_ff   <= vlen_in;
         hname_ff  <= hname_in;
         hfile_ff  <= hfile_in;
         long_ff   <= long_in;
      end
   end

   a_long_at_limit: assert property (@(posedge clock) disable iff (reset)
      long_ff |-> (pos_ff == MaxPos))
      else $error("overflow flag set below the length limit");

   a_reject_idles: assert property (@(posedge clock) disable iff (reset)
      (bad_ff && !first_ff) |-> (phase_ff == PH_LEAD))
      else $error("parser left lead phase after rejection");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> ((pos_ff == '0) && first_ff && !long_ff && !hname_ff.found && !hfile_ff.found))
      else $error("state not cleared after final byte");

   a_value_not_first: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_VALUE) || (phase_ff == PH_POST)) |-> !first_ff)
      else $error("quoted value inside first segment");

endmodule

FILE: rtl/fddp_out_stage.sv
`timescale 1ns / 1ps
// Result register: holds one result beat until the response side takes it.
// Depends on fddp_pkg.
module fddp_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  fddp_pkg::result_type          result,
   output logic                          out_free,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fddp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import fddp_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000,
                        res_ff.file.len, res_ff.file.start, res_ff.file.found,
                        res_ff.name.len, res_ff.name.start, res_ff.name.found,
                        res_ff.status};

   a_fail_is_empty: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (res_ff.status != STATUS_OK)) |->
         ((res_ff.name == '0) && (res_ff.file == '0)))
      else $error("failed result carries span fields");

endmodule

FILE: rtl/form_data_disposition_parser.sv
`timescale 1ns / 1ps
// Timing: a non-final byte is parsed the cycle after it is accepted; a final byte
// waits for a free result register, which then holds its result for the rsp side.
// Throughput: one byte per cycle, set by the single parse stage between the input
// and result registers; a final byte waits while a full result is not yet taken.
// Reset: synchronous, active high; clears the handshake state and all parser state.
// Depends on fddp_pkg, fddp_in_stage, fddp_parse_core and fddp_out_stage.
module form_data_disposition_parser #(
   parameter int MAX_LEN = fddp_pkg::MAX_LEN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request beats: one byte of the disposition value each.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] in_byte
   input  logic                            req_tlast,   // is_final
   // Result beats: one per value, on its final byte.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [2] name_found, [14:3] name_start, [26:15] name_len,
   // [27] file_found, [39:28] file_start, [51:40] file_len, [55:52] zero
   output logic [fddp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import fddp_pkg::*;

   step_type   step;
   result_type result;
   logic       emit;
   logic       out_free;

   // Hold the incoming beat; advance it whenever the parser can take it.
   fddp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_free   (out_free),
      .step       (step)
   );

   // Advance the segment parser by one byte; build the result on the final byte.
   fddp_parse_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .emit   (emit),
      .result (result)
   );

   // Hold the result beat until the response side takes it.
   fddp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
